// ===== src/ctf_pkg.sv =====
package ctf_pkg;

    localparam int MAX_FIELDS = 256;
    localparam logic [7:0] FIELD_LIMIT = (MAX_FIELDS - 1 > 255) ? 8'd255 : 8'(MAX_FIELDS - 1);

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] CR_CHAR    = 8'h0D;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_QUOTE    = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] comment_char;
        logic       skip_empty_lines;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       field_end;
        logic       record_end;
        logic [7:0] field_number;
        logic [1:0] error_code;
    } res_t;

    // two set: both results valid; otherwise only first
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } entry_t;

endpackage

// ===== src/ctf_front.sv =====
module ctf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  ctf_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    input  logic          q_full,
    output logic          push,
    output ctf_pkg::entry_t push_entry
);

    typedef enum logic [2:0] {
        MODE_RECORD,
        MODE_FIELD,
        MODE_QUOTED,
        MODE_QUOTE_SEEN,
        MODE_SKIP
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic       fhb;
        logic       parity;
        logic [7:0] cnt;
    } pst_t;

    typedef struct packed {
        pst_t          st;
        logic          vld;
        ctf_pkg::res_t res;
    } pout_t;

    function automatic ctf_pkg::res_t mk_res(input logic [7:0] db, input logic dv,
                                             input logic fe, input logic re,
                                             input logic [1:0] err, input logic [7:0] num);
        ctf_pkg::res_t r;
        r.data_byte    = db;
        r.data_valid   = dv;
        r.field_end    = fe;
        r.record_end   = re;
        r.field_number = num;
        r.error_code   = err;
        return r;
    endfunction

    function automatic pst_t rec_start();
        pst_t s;
        s.mode   = MODE_RECORD;
        s.fhb    = 1'b0;
        s.parity = 1'b0;
        s.cnt    = 8'd0;
        return s;
    endfunction

    function automatic pout_t field_byte(input pst_t s, input logic [7:0] c,
                                         input ctf_pkg::cfg_t cf);
        pout_t o;
        o.st  = s;
        o.vld = 1'b1;
        o.res = mk_res(8'd0, 1'b0, 1'b1, 1'b1, ctf_pkg::ERR_NONE, s.cnt);
        priority if (c == ctf_pkg::LF_CHAR) begin
            o.st = rec_start();
        end else if (c == ctf_pkg::QUOTE_CHAR) begin
            if (s.fhb) begin
                o.res       = mk_res(8'd0, 1'b0, 1'b0, 1'b1, ctf_pkg::ERR_QUOTE, s.cnt);
                o.st        = rec_start();
                o.st.mode   = MODE_SKIP;
                o.st.parity = 1'b1;
            end else begin
                o.vld     = 1'b0;
                o.st.mode = MODE_QUOTED;
            end
        end else if (c == cf.delimiter_char) begin
            o.res    = mk_res(8'd0, 1'b0, 1'b1, 1'b0, ctf_pkg::ERR_NONE, s.cnt);
            o.st.fhb = 1'b0;
            if (s.cnt < ctf_pkg::FIELD_LIMIT) begin
                o.st.cnt = s.cnt + 8'd1;
            end
        end else begin
            o.res    = mk_res(c, 1'b1, 1'b0, 1'b0, ctf_pkg::ERR_NONE, s.cnt);
            o.st.fhb = 1'b1;
        end
        return o;
    endfunction

    function automatic pout_t process(input pst_t s, input logic [7:0] c,
                                      input ctf_pkg::cfg_t cf);
        pout_t o;
        pst_t  t;
        o.st  = s;
        o.vld = 1'b0;
        o.res = mk_res(c, 1'b1, 1'b0, 1'b0, ctf_pkg::ERR_NONE, s.cnt);
        t     = s;
        unique case (s.mode)
            MODE_FIELD: begin
                o = field_byte(s, c, cf);
            end
            MODE_QUOTED: begin
                if (c == ctf_pkg::QUOTE_CHAR) begin
                    o.st.mode = MODE_QUOTE_SEEN;
                end else begin
                    o.vld    = 1'b1;
                    o.st.fhb = 1'b1;
                end
            end
            MODE_QUOTE_SEEN: begin
                if (c == ctf_pkg::QUOTE_CHAR) begin
                    o.vld     = 1'b1;
                    o.st.fhb  = 1'b1;
                    o.st.mode = MODE_QUOTED;
                end else begin
                    t.mode = MODE_FIELD;
                    o      = field_byte(t, c, cf);
                end
            end
            MODE_SKIP: begin
                if (c == ctf_pkg::QUOTE_CHAR) begin
                    o.st.parity = ~s.parity;
                end else if (c == ctf_pkg::LF_CHAR && !s.parity) begin
                    o.st = rec_start();
                end
            end
            default: begin
                if (c == ctf_pkg::LF_CHAR) begin
                    o.vld = ~cf.skip_empty_lines;
                    o.res = mk_res(8'd0, 1'b0, 1'b1, 1'b1, ctf_pkg::ERR_NONE, s.cnt);
                    o.st  = rec_start();
                end else if (cf.comment_char != 8'd0 && c == cf.comment_char) begin
                    o.st.mode   = MODE_SKIP;
                    o.st.parity = (c == ctf_pkg::QUOTE_CHAR);
                end else begin
                    t.mode = MODE_FIELD;
                    t.fhb  = 1'b0;
                    o      = field_byte(t, c, cf);
                end
            end
        endcase
        return o;
    endfunction

    pst_t          st_reg, st_next, st1;
    logic          cr_reg, cr_next;
    logic          accept;
    logic          do_first, do_second, v1, v2;
    logic [7:0]    first_byte;
    pout_t         p1, p2;
    ctf_pkg::res_t r2;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        do_first   = 1'b0;
        do_second  = 1'b0;
        first_byte = s_tdata;
        cr_next    = 1'b0;
        if (s_tuser) begin
            do_first   = cr_reg;
            first_byte = ctf_pkg::LF_CHAR;
        end else if (cr_reg) begin
            do_first = 1'b1;
            if (s_tdata == ctf_pkg::LF_CHAR) begin
                first_byte = ctf_pkg::LF_CHAR;
            end else begin
                first_byte = ctf_pkg::CR_CHAR;
                if (s_tdata == ctf_pkg::CR_CHAR) begin
                    cr_next = 1'b1;
                end else begin
                    do_second = 1'b1;
                end
            end
        end else if (s_tdata == ctf_pkg::CR_CHAR) begin
            cr_next = 1'b1;
        end else begin
            do_first = 1'b1;
        end

        p1  = process(st_reg, first_byte, cfg);
        st1 = do_first ? p1.st : st_reg;
        v1  = do_first & p1.vld;
        p2  = process(st1, s_tdata, cfg);

        if (s_tuser) begin
            v2 = (st1.mode == MODE_FIELD) || (st1.mode == MODE_QUOTE_SEEN)
                 || (st1.mode == MODE_QUOTED);
            r2 = (st1.mode == MODE_QUOTED)
                 ? mk_res(8'd0, 1'b0, 1'b0, 1'b1, ctf_pkg::ERR_UNCLOSED, st1.cnt)
                 : mk_res(8'd0, 1'b0, 1'b1, 1'b1, ctf_pkg::ERR_NONE, st1.cnt);
            st_next = rec_start();
        end else begin
            v2      = do_second & p2.vld;
            r2      = p2.res;
            st_next = do_second ? p2.st : st1;
        end

        if (v1) begin
            push_entry.two    = v2;
            push_entry.first  = p1.res;
            push_entry.second = r2;
        end else begin
            push_entry.two    = 1'b0;
            push_entry.first  = r2;
            push_entry.second = r2;
        end
        push = accept & (v1 | v2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= rec_start();
            cr_reg <= 1'b0;
        end else if (accept) begin
            st_reg <= st_next;
            cr_reg <= cr_next;
        end
    end

endmodule

// ===== src/ctf_queue.sv =====
module ctf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ctf_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output ctf_pkg::entry_t q_entry
);

    ctf_pkg::entry_t                  mem_reg [ctf_pkg::QUEUE_DEPTH];
    logic [ctf_pkg::QPTR_W-1:0]       wr_reg, rd_reg;
    logic [ctf_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign full    = (cnt_reg == ctf_pkg::QCNT_W'(ctf_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + ctf_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - ctf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + ctf_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + ctf_pkg::QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/ctf_back.sv =====
module ctf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  ctf_pkg::entry_t q_entry,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [23:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    ctf_pkg::entry_t ent_reg;
    logic            vld_reg;
    logic            idx_reg;
    logic            last;
    ctf_pkg::res_t   cur;

    assign cur      = idx_reg ? ent_reg.second : ent_reg.first;
    assign last     = ~ent_reg.two | idx_reg;
    assign m_tvalid = vld_reg;
    assign m_tlast  = last;
    assign m_tuser  = cur.error_code;
    assign m_tdata  = {5'd0, cur.field_number, cur.record_end, cur.field_end,
                       cur.data_valid, cur.data_byte};
    assign pop      = q_valid & (~vld_reg | (m_tready & last));

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent_reg <= q_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            idx_reg <= 1'b0;
        end else if (pop) begin
            vld_reg <= 1'b1;
            idx_reg <= 1'b0;
        end else if (vld_reg && m_tready) begin
            if (last) begin
                vld_reg <= 1'b0;
                idx_reg <= 1'b0;
            end else begin
                idx_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== src/csv_field_tokenizer_unit.sv =====
// Each result is registered in the four-entry queue and then in the output register on its
// way from an accepted input item to m_.
// Throughput: one input item per cycle while the queue has room; results leave one per
// cycle while m_tready is high, so items with two results each lower the sustained rate.
// Reset: synchronous active-low aresetn clears parser state, queue and output, and sets
// the configuration to delimiter 44, comment 0, skip empty lines 1.
module csv_field_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [8] data_valid, [9] field_end,
                                   // [10] record_end, [18:11] field_number, [23:19] zero
    output logic [1:0]  m_tuser,   // [1:0] error_code
    output logic        m_tlast    // last_result
);

    localparam logic [1:0] REG_DELIM      = 2'd0;
    localparam logic [1:0] REG_COMMENT    = 2'd1;
    localparam logic [1:0] REG_SKIP_EMPTY = 2'd2;

    ctf_pkg::cfg_t   cfg_reg;
    logic            wr_en;
    logic            q_full, push, pop, q_valid;
    ctf_pkg::entry_t push_entry, q_entry;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_char   <= 8'd44;
            cfg_reg.comment_char     <= 8'd0;
            cfg_reg.skip_empty_lines <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_DELIM:      cfg_reg.delimiter_char   <= pwdata[7:0];
                REG_COMMENT:    cfg_reg.comment_char     <= pwdata[7:0];
                REG_SKIP_EMPTY: cfg_reg.skip_empty_lines <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DELIM:      prdata = {24'd0, cfg_reg.delimiter_char};
            REG_COMMENT:    prdata = {24'd0, cfg_reg.comment_char};
            REG_SKIP_EMPTY: prdata = {31'd0, cfg_reg.skip_empty_lines};
            default:        prdata = 32'd0;
        endcase
    end

    ctf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ctf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    ctf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/csv_token_checker.sv =====
`timescale 1ns / 1ps

module csv_token_checker
    import ctf_pkg::*;
#(
    parameter logic [3:0] DELIM_ADDR   = 4'h0,
    parameter logic [3:0] COMMENT_ADDR = 4'h4,
    parameter logic [3:0] SKIP_ADDR    = 4'h8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] data_byte, [8] data_valid, [9] field_end,
                                   // [10] record_end, [18:11] field_number, [23:19] zero
    input  logic [1:0]  m_tuser,   // [1:0] error_code
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_count
);

    localparam logic [7:0] DELIM_AT_RESET   = 8'd44;
    localparam logic [7:0] COMMENT_AT_RESET = 8'd0;
    localparam logic       SKIP_AT_RESET    = 1'b1;

    typedef enum logic [2:0] {
        PM_RECORD,
        PM_FIELD,
        PM_QUOTED,
        PM_QUOTE_SEEN,
        PM_SKIP
    } parse_mode_e;

    typedef struct packed {
        res_t res;
        logic last;
    } token_t;

    cfg_t        cfg;
    parse_mode_e mode;
    logic        field_open;
    logic        record_open;
    logic        cr_held;
    logic        skip_parity;
    logic [7:0]  field_idx;
    int          mismatches = 0;

    token_t step_tokens[$];
    token_t expected_tokens[$];

    function automatic void put_token(input logic [7:0] db, input logic dv, input logic fe,
                                      input logic re, input logic [1:0] err);
        token_t t;
        t.res.data_byte    = db;
        t.res.data_valid   = dv;
        t.res.field_end    = fe;
        t.res.record_end   = re;
        t.res.field_number = field_idx;
        t.res.error_code   = err;
        t.last             = 1'b0;
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void close_record();
        mode        = PM_RECORD;
        field_open  = 1'b0;
        record_open = 1'b0;
        field_idx   = 8'd0;
        skip_parity = 1'b0;
    endfunction

    function automatic void field_char(input logic [7:0] c);
        if (c == LF_CHAR) begin
            put_token(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
            close_record();
        end else if (c == QUOTE_CHAR) begin
            if (field_open) begin
                put_token(8'd0, 1'b0, 1'b0, 1'b1, ERR_QUOTE);
                close_record();
                mode        = PM_SKIP;
                skip_parity = 1'b1;
                record_open = 1'b1;
            end else begin
                mode = PM_QUOTED;
            end
        end else if (c == cfg.delimiter_char) begin
            put_token(8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
            field_open = 1'b0;
            if (field_idx < FIELD_LIMIT)
                field_idx = field_idx + 8'd1;
        end else begin
            put_token(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
            field_open = 1'b1;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        case (mode)
            PM_FIELD: begin
                field_char(c);
            end
            PM_QUOTED: begin
                if (c == QUOTE_CHAR) begin
                    mode = PM_QUOTE_SEEN;
                end else begin
                    put_token(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    field_open = 1'b1;
                end
            end
            PM_QUOTE_SEEN: begin
                if (c == QUOTE_CHAR) begin
                    put_token(QUOTE_CHAR, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    field_open = 1'b1;
                    mode       = PM_QUOTED;
                end else begin
                    mode = PM_FIELD;
                    field_char(c);
                end
            end
            PM_SKIP: begin
                if (c == QUOTE_CHAR)
                    skip_parity = ~skip_parity;
                else if (c == LF_CHAR && !skip_parity)
                    close_record();
            end
            default: begin
                if (c == LF_CHAR) begin
                    if (!cfg.skip_empty_lines)
                        put_token(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    close_record();
                end else begin
                    record_open = 1'b1;
                    if (cfg.comment_char != 8'd0 && c == cfg.comment_char) begin
                        mode        = PM_SKIP;
                        skip_parity = (c == QUOTE_CHAR);
                    end else begin
                        mode       = PM_FIELD;
                        field_open = 1'b0;
                        field_char(c);
                    end
                end
            end
        endcase
    endfunction

    function automatic void predict_item(input logic end_of_input, input logic [7:0] c);
        token_t t;
        step_tokens.delete();
        if (end_of_input) begin
            if (cr_held) begin
                cr_held = 1'b0;
                parse_char(LF_CHAR);
            end
            if (mode == PM_FIELD || mode == PM_QUOTE_SEEN)
                put_token(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
            else if (mode == PM_QUOTED)
                put_token(8'd0, 1'b0, 1'b0, 1'b1, ERR_UNCLOSED);
            close_record();
        end else if (cr_held) begin
            cr_held = 1'b0;
            if (c == LF_CHAR) begin
                parse_char(LF_CHAR);
            end else begin
                parse_char(CR_CHAR);
                if (c == CR_CHAR)
                    cr_held = 1'b1;
                else
                    parse_char(c);
            end
        end else if (c == CR_CHAR) begin
            cr_held = 1'b1;
        end else begin
            parse_char(c);
        end
        for (int i = 0; i < step_tokens.size(); i++) begin
            t = step_tokens[i];
            if (i == step_tokens.size() - 1)
                t.last = 1'b1;
            expected_tokens = {expected_tokens, t};
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        token_t want;
        if (!aresetn) begin
            cfg.delimiter_char   = DELIM_AT_RESET;
            cfg.comment_char     = COMMENT_AT_RESET;
            cfg.skip_empty_lines = SKIP_AT_RESET;
            cr_held              = 1'b0;
            close_record();
            expected_tokens.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    DELIM_ADDR:   cfg.delimiter_char   = pwdata[7:0];
                    COMMENT_ADDR: cfg.comment_char     = pwdata[7:0];
                    SKIP_ADDR:    cfg.skip_empty_lines = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, {5'd0, m_tlast, m_tuser, m_tdata});
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_tdata[7:0] !== want.res.data_byte)
                        report_mismatch("data_byte", 32'(want.res.data_byte),
                                        32'(m_tdata[7:0]));
                    if (m_tdata[8] !== want.res.data_valid)
                        report_mismatch("data_valid", 32'(want.res.data_valid),
                                        32'(m_tdata[8]));
                    if (m_tdata[9] !== want.res.field_end)
                        report_mismatch("field_end", 32'(want.res.field_end),
                                        32'(m_tdata[9]));
                    if (m_tdata[10] !== want.res.record_end)
                        report_mismatch("record_end", 32'(want.res.record_end),
                                        32'(m_tdata[10]));
                    if (m_tdata[18:11] !== want.res.field_number)
                        report_mismatch("field_number", 32'(want.res.field_number),
                                        32'(m_tdata[18:11]));
                    if (m_tdata[23:19] !== 5'd0)
                        report_mismatch("tdata padding", 32'd0, 32'(m_tdata[23:19]));
                    if (m_tuser !== want.res.error_code)
                        report_mismatch("error_code", 32'(want.res.error_code), 32'(m_tuser));
                    if (m_tlast !== want.last)
                        report_mismatch("last_result", 32'(want.last), 32'(m_tlast));
                end
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_tokens.size();
    end

endmodule

// ===== tb/tb_csv_field_tokenizer_unit.sv =====
`timescale 1ns / 1ps

module tb_csv_field_tokenizer_unit;
    import ctf_pkg::*;

    localparam logic [3:0] DELIM_ADDR   = 4'h0;
    localparam logic [3:0] COMMENT_ADDR = 4'h4;
    localparam logic [3:0] SKIP_ADDR    = 4'h8;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] TAB_CHAR = 8'h09;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] in_byte
    logic        s_tuser = 1'b0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [7:0] data_byte, [8] data_valid, [9] field_end,
                                   // [10] record_end, [18:11] field_number, [23:19] zero
    logic [1:0]  m_tuser;          // [1:0] error_code
    logic        m_tlast;

    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   sink_hold = 0;
    int   sink_wait = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;
    logic calm = 1'b0;
    logic offering = 1'b0;

    logic [7:0] delim_now   = 8'd44;
    logic [7:0] comment_now = 8'd0;
    logic       skip_now    = 1'b1;

    csv_field_tokenizer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csv_token_checker #(
        .DELIM_ADDR   (DELIM_ADDR),
        .COMMENT_ADDR (COMMENT_ADDR),
        .SKIP_ADDR    (SKIP_ADDR)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (fail_count),
        .pending_count  (pending_count)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("csv_field_tokenizer_unit verification failed");
            $finish;
        end
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // hold ready low for a requested stretch first, then random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (hold_req != hold_seen) begin
            m_tready  <= 1'b0;
            hold_seen <= hold_req;
            sink_hold <= HOLD_CYCLES;
        end else if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_wait != 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0)
                sink_wait <= pause_len();
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= act;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        g = calm ? 0 : pause_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_BYTE, b);
    endtask

    task automatic wait_quiet();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] d, input logic [7:0] c, input logic s);
        wait_quiet();
        apb_write(DELIM_ADDR, {24'd0, d});
        apb_write(COMMENT_ADDR, {24'd0, c});
        apb_write(SKIP_ADDR, {31'd0, s});
        delim_now   = d;
        comment_now = c;
        skip_now    = s;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == QUOTE_CHAR || b == LF_CHAR || b == CR_CHAR || b == delim_now ||
               b == comment_now);
        return b;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(0, 2) == 0)
            send_byte(CR_CHAR);
        send_byte(LF_CHAR);
    endtask

    // skip content with quote parity tracked, closed by an even-parity newline
    task automatic send_skipped_tail(input logic parity);
        logic p;
        p = parity;
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(QUOTE_CHAR);
                    p = ~p;
                end
                1: if (p) send_byte(LF_CHAR);
                default: send_byte(plain_byte());
            endcase
        end
        if (p)
            send_byte(QUOTE_CHAR);
        send_line_end();
    endtask

    task automatic send_record();
        int nf;
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
            if (f > 0)
                send_byte(delim_now);
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(0, 4)) send_byte(plain_byte());
            end else begin
                send_byte(QUOTE_CHAR);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 5))
                        3: send_byte(delim_now);
                        4: send_line_end();
                        5: begin
                            send_byte(QUOTE_CHAR);
                            send_byte(QUOTE_CHAR);
                        end
                        default: send_byte(plain_byte());
                    endcase
                end
                send_byte(QUOTE_CHAR);
                if ($urandom_range(0, 7) == 0)
                    send_byte(plain_byte());
            end
        end
        if ($urandom_range(0, 19) == 0)
            send_item(ACT_END, 8'($urandom_range(0, 255)));
        else
            send_line_end();
    endtask

    task automatic send_broken();
        if ($urandom_range(0, 1) == 0) begin
            send_byte(QUOTE_CHAR);
            repeat ($urandom_range(0, 3)) send_byte(plain_byte());
            send_item(ACT_END, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(plain_byte());
            send_byte(QUOTE_CHAR);
            send_skipped_tail(1'b1);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0: send_byte(QUOTE_CHAR);
                1: send_byte(LF_CHAR);
                2: send_byte(CR_CHAR);
                3: send_byte(delim_now);
                4: send_byte(comment_now);
                5: send_item(ACT_END, 8'($urandom_range(0, 255)));
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int r;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 29) == 0)
                calm <= ~calm;
            r = $urandom_range(0, 99);
            if (r < 68) begin
                send_record();
            end else if (r < 80) begin
                send_broken();
            end else if (r < 88) begin
                if (comment_now != 8'd0 && $urandom_range(0, 1) == 0) begin
                    send_byte(comment_now);
                    send_skipped_tail(comment_now == QUOTE_CHAR);
                end else begin
                    send_line_end();
                end
            end else if (r < 96) begin
                send_noise();
            end else begin
                send_item(ACT_END, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // quoted field with escaped quote, trailing byte after close, CRLF
        send_byte("a");
        send_byte(delim_now);
        send_byte(QUOTE_CHAR);
        send_byte("b");
        send_byte(QUOTE_CHAR);
        send_byte(QUOTE_CHAR);
        send_byte(8'h00);
        send_byte(QUOTE_CHAR);
        send_byte(8'hFF);
        send_byte(CR_CHAR);
        send_byte(LF_CHAR);
        // lone CR is data
        send_byte(CR_CHAR);
        send_byte("z");
        send_item(ACT_END, 8'h00);
        // quote inside an unquoted field, skip up to even-parity newline
        send_byte("q");
        send_byte(QUOTE_CHAR);
        send_byte(QUOTE_CHAR);
        send_byte(LF_CHAR);
        send_byte(LF_CHAR);
        // unclosed quote at end of input
        send_byte(QUOTE_CHAR);
        send_byte(8'h7F);
        send_item(ACT_END, 8'hFF);
        // pending CR at end of input, then end with nothing open
        send_byte("k");
        send_byte(CR_CHAR);
        send_item(ACT_END, 8'h5A);
        send_item(ACT_END, 8'hA5);

        set_config(";", "#", 1'b0);
        send_byte(LF_CHAR);
        send_byte("#");
        send_byte(QUOTE_CHAR);
        send_byte(LF_CHAR);
        send_byte(QUOTE_CHAR);
        send_byte(LF_CHAR);

        // stall the result side long enough to back up the input
        hold_req <= ~hold_req;
        run_random(150);
        // one record wide enough to saturate the field index
        repeat (260) send_byte(delim_now);
        send_byte(LF_CHAR);
        run_random(150);

        set_config(8'h00, QUOTE_CHAR, 1'b1);
        run_random(200);
        set_config(8'hFF, 8'hFF, 1'b0);
        run_random(200);
        set_config(TAB_CHAR, 8'h00, 1'b1);
        run_random(200);
        set_config(QUOTE_CHAR, "#", 1'b0);
        run_random(150);
        set_config(LF_CHAR, CR_CHAR, 1'b1);
        run_random(150);
        set_config(8'd44, 8'h00, 1'b1);
        run_random(200);

        wait_quiet();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("csv_field_tokenizer_unit verification clean");
        else
            $display("csv_field_tokenizer_unit verification failed");
        $finish;
    end

endmodule
